@@ design/bcu_pkg.sv @@
package bcu_pkg;

    // Default word width of the datapath
    localparam int WIDTH_DEF = 32;

    // Width of the n, k and coefficient fields on the channels
    localparam int FIELD_W = 32;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_TEST,
        ST_DIV_C,
        ST_MUL_Q,
        ST_MUL_R,
        ST_DIV_R,
        ST_DONE
    } t_state;

    typedef enum logic {
        OP_DIV,
        OP_MUL
    } t_alu_op;

    typedef struct packed {
        logic    start;
        t_alu_op op;
    } t_alu_req;

    typedef struct packed {
        logic done;
    } t_alu_rsp;

endpackage

@@ design/bcu_if.sv @@
interface bcu_in_if;
    logic                         valid;
    logic                         ready;
    logic [bcu_pkg::FIELD_W-1:0]  n;
    logic [bcu_pkg::FIELD_W-1:0]  k;

    modport source (output valid, output n, output k, input ready);
    modport sink   (input valid, input n, input k, output ready);
endinterface

interface bcu_out_if;
    logic                         valid;
    logic                         ready;
    logic [bcu_pkg::FIELD_W-1:0]  coefficient;

    modport source (output valid, output coefficient, input ready);
    modport sink   (input valid, input coefficient, output ready);
endinterface

@@ design/bcu_alu.sv @@
// Bit-serial divide / multiply, one bit per cycle while busy; done pulses
// once the last bit is done.
// DIV: o_lo = a / b, o_hi = a % b (b nonzero).
// MUL: {o_hi, o_lo} = a * b, full double-width product.
module bcu_alu #(
    parameter int WIDTH = bcu_pkg::WIDTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  bcu_pkg::t_alu_req   i_req,
    input  logic [WIDTH-1:0]    i_a,
    input  logic [WIDTH-1:0]    i_b,
    output bcu_pkg::t_alu_rsp   o_rsp,
    output logic [WIDTH-1:0]    o_lo,
    output logic [WIDTH-1:0]    o_hi
);

    localparam int CW = $clog2(WIDTH + 1);

    logic              r_busy;
    logic              r_done;
    logic [CW-1:0]     r_cnt;
    bcu_pkg::t_alu_op  r_op;
    logic [WIDTH-1:0]  r_hi;
    logic [WIDTH-1:0]  r_lo;
    logic [WIDTH-1:0]  r_opnd;

    logic [WIDTH:0]    w_shift;
    logic [WIDTH:0]    w_trial;
    logic [WIDTH:0]    w_sum;

    // adders: restoring subtract for DIV, add of multiplicand for MUL
    always_comb begin
        w_shift = {r_hi, r_lo[WIDTH-1]};
        w_trial = w_shift - {1'b0, r_opnd};
        w_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_opnd} : '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end else if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(WIDTH);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            if (r_op == bcu_pkg::OP_DIV) begin
                if (!w_trial[WIDTH]) begin
                    r_hi <= w_trial[WIDTH-1:0];
                    r_lo <= {r_lo[WIDTH-2:0], 1'b1};
                end else begin
                    r_hi <= w_shift[WIDTH-1:0];
                    r_lo <= {r_lo[WIDTH-2:0], 1'b0};
                end
            end else begin
                r_hi <= w_sum[WIDTH:1];
                r_lo <= {w_sum[0], r_lo[WIDTH-1:1]};
            end
        end else if (i_req.start) begin
            r_op <= i_req.op;
            r_hi <= '0;
            if (i_req.op == bcu_pkg::OP_DIV) begin
                r_lo   <= i_a;
                r_opnd <= i_b;
            end else begin
                r_lo   <= i_b;
                r_opnd <= i_a;
            end
        end
    end

    assign o_rsp.done = r_done;
    assign o_lo       = r_lo;
    assign o_hi       = r_hi;

endmodule

@@ design/binomial_coefficient_unit.sv @@
// Binomial coefficient unit: C(n,k) on WIDTH-bit unsigned words.
//
// Channels: i_in takes one word of n and k, o_out returns one word with the
// coefficient. A word moves on a rising edge with valid and ready both high.
// A coefficient of zero means overflow, or k greater than n.
//
// k is first folded to min(k, n-k). One loop step then runs per i = 1..k on a
// single bit-serial divide/multiply unit: c/i and c%i, (c/i)*m with overflow
// check on the high half, (c%i)*m, that product divided by i, then the add.
// The four operations of a step run one after another on the unit, and the
// loop stops early at the first overflowing product. Items are handled one at a
// time: i_in.ready is high only while the sequencer is idle.
//
// The result sits in an output register. If the receiver stalls, the result
// holds and the block may already accept the next word; that word's result
// waits in the final state until the register is free.
// Reset (synchronous, active low) returns the sequencer to idle and drops
// o_out.valid. n and k are cut to WIDTH bits; the output keeps the low 32.
module binomial_coefficient_unit #(
    parameter int WIDTH = bcu_pkg::WIDTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bcu_in_if.sink      i_in,
    bcu_out_if.source   o_out
);

    bcu_pkg::t_state   r_state;
    bcu_pkg::t_state   n_state;

    // loop registers
    logic [WIDTH-1:0]  r_n;
    logic [WIDTH-1:0]  r_k;
    logic [WIDTH-1:0]  r_c;
    logic [WIDTH-1:0]  r_i;
    logic [WIDTH-1:0]  r_m;
    logic [WIDTH-1:0]  r_q;

    // output register
    logic                         r_out_valid;
    logic [bcu_pkg::FIELD_W-1:0]  r_coef;

    // shared unit
    bcu_pkg::t_alu_req w_req;
    bcu_pkg::t_alu_rsp w_rsp;
    logic [WIDTH-1:0]  w_a;
    logic [WIDTH-1:0]  w_b;
    logic [WIDTH-1:0]  w_lo;
    logic [WIDTH-1:0]  w_hi;

    logic              w_in_take;
    logic              w_out_free;
    logic [WIDTH-1:0]  w_nk;

    assign w_in_take  = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_nk       = r_n - r_k;

    bcu_alu #(
        .WIDTH (WIDTH)
    ) u_alu (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .o_rsp   (w_rsp),
        .o_lo    (w_lo),
        .o_hi    (w_hi)
    );

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            bcu_pkg::ST_IDLE: begin
                if (w_in_take) n_state = bcu_pkg::ST_PREP;
            end
            bcu_pkg::ST_PREP: begin
                n_state = (r_k > r_n) ? bcu_pkg::ST_DONE : bcu_pkg::ST_TEST;
            end
            bcu_pkg::ST_TEST: begin
                n_state = (r_i > r_k) ? bcu_pkg::ST_DONE : bcu_pkg::ST_DIV_C;
            end
            bcu_pkg::ST_DIV_C: begin
                if (w_rsp.done) n_state = bcu_pkg::ST_MUL_Q;
            end
            bcu_pkg::ST_MUL_Q: begin
                if (w_rsp.done) begin
                    n_state = (w_hi != '0) ? bcu_pkg::ST_DONE : bcu_pkg::ST_MUL_R;
                end
            end
            bcu_pkg::ST_MUL_R: begin
                if (w_rsp.done) n_state = bcu_pkg::ST_DIV_R;
            end
            bcu_pkg::ST_DIV_R: begin
                if (w_rsp.done) n_state = bcu_pkg::ST_TEST;
            end
            bcu_pkg::ST_DONE: begin
                if (w_out_free) n_state = bcu_pkg::ST_IDLE;
            end
            default: n_state = bcu_pkg::ST_IDLE;
        endcase
    end

    // outputs: unit requests and operands, and i_in.ready
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = bcu_pkg::OP_DIV;
        w_a         = r_c;
        w_b         = r_i;
        i_in.ready  = 1'b0;
        case (r_state)
            bcu_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
            end
            bcu_pkg::ST_TEST: begin
                // c / i, c % i
                w_req.start = !(r_i > r_k);
                w_req.op    = bcu_pkg::OP_DIV;
                w_a         = r_c;
                w_b         = r_i;
            end
            bcu_pkg::ST_DIV_C: begin
                // (c/i) * m
                w_req.start = w_rsp.done;
                w_req.op    = bcu_pkg::OP_MUL;
                w_a         = w_lo;
                w_b         = r_m;
            end
            bcu_pkg::ST_MUL_Q: begin
                // (c%i) * m, remainder parked in r_c
                w_req.start = w_rsp.done && (w_hi == '0);
                w_req.op    = bcu_pkg::OP_MUL;
                w_a         = r_c;
                w_b         = r_m;
            end
            bcu_pkg::ST_MUL_R: begin
                // ((c%i)*m mod 2^W) / i
                w_req.start = w_rsp.done;
                w_req.op    = bcu_pkg::OP_DIV;
                w_a         = w_lo;
                w_b         = r_i;
            end
            default: begin
                w_req.start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bcu_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // loop datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            bcu_pkg::ST_IDLE: begin
                if (w_in_take) begin
                    r_n <= WIDTH'(i_in.n);
                    r_k <= WIDTH'(i_in.k);
                end
            end
            bcu_pkg::ST_PREP: begin
                r_c <= (r_k > r_n) ? '0 : WIDTH'(1);
                r_i <= WIDTH'(1);
                r_m <= r_n;
                if (r_k > w_nk) r_k <= w_nk;
            end
            bcu_pkg::ST_DIV_C: begin
                if (w_rsp.done) r_c <= w_hi;
            end
            bcu_pkg::ST_MUL_Q: begin
                if (w_rsp.done) begin
                    if (w_hi != '0) begin
                        r_c <= '0;
                    end else begin
                        r_q <= w_lo;
                    end
                end
            end
            bcu_pkg::ST_DIV_R: begin
                if (w_rsp.done) begin
                    r_c <= r_q + w_lo;
                    r_i <= r_i + 1'b1;
                    r_m <= r_m - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == bcu_pkg::ST_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == bcu_pkg::ST_DONE && w_out_free) begin
            r_coef <= bcu_pkg::FIELD_W'(r_c);
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.coefficient = r_coef;

    // running factor and index stay tied: m + i == n + 1 inside the loop
    a_loop_tie: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bcu_pkg::ST_TEST || r_state == bcu_pkg::ST_DIV_C ||
         r_state == bcu_pkg::ST_MUL_Q || r_state == bcu_pkg::ST_MUL_R ||
         r_state == bcu_pkg::ST_DIV_R) |-> (r_m + r_i == r_n + 1'b1))
        else $error("loop factor and index out of step");

    // unit completions only arrive while the sequencer waits on one
    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rsp.done |-> (r_state == bcu_pkg::ST_DIV_C || r_state == bcu_pkg::ST_MUL_Q ||
                        r_state == bcu_pkg::ST_MUL_R || r_state == bcu_pkg::ST_DIV_R))
        else $error("unit completion outside a wait state");

    // a new result is loaded only from the final state
    a_load_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == bcu_pkg::ST_DONE))
        else $error("result loaded outside final state");

    // the divisor never reaches zero in a step
    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.start && w_req.op == bcu_pkg::OP_DIV) |-> (w_b != '0))
        else $error("divide by zero requested");

endmodule
